FILE: src/wtsa_pkg.sv
package wtsa_pkg;

    localparam int WEIGHT_W  = 8;
    localparam int TOKEN_W   = 8;
    localparam int DEFICIT_W = 10;
    localparam int TOTAL_W   = 10;
    localparam int SUM_W     = 17;
    localparam int CNT_W     = 5;
    localparam int NUM_REQ   = 3;
    localparam int ADDR_W    = 4;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_FIRST_WEIGHT  = 2'd0,
        REG_SECOND_WEIGHT = 2'd1,
        REG_THIRD_WEIGHT  = 2'd2,
        REG_LOAD_BUDGET   = 2'd3
    } reg_idx_t;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;
    localparam logic [WEIGHT_W-1:0] BUDGET_RESET = 8'd4;
    localparam logic [TOKEN_W-1:0]  TOKEN_MAX    = 8'hFF;
    localparam logic [CNT_W-1:0]    LAST_STEP    = 5'(SUM_W - 1);

    typedef struct packed {
        logic first_has_work;
        logic second_has_work;
        logic third_has_work;
    } req_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] first_tokens;
        logic [TOKEN_W-1:0] second_tokens;
        logic [TOKEN_W-1:0] third_tokens;
        logic               nothing_pending;
    } grant_t;

endpackage

FILE: src/weighted_token_share_allocator.sv
// An idle tick (no active weight) goes straight to the finish state once accepted;
// otherwise each requester is loaded in turn and, if active, divided and stored.
// No new tick is taken until the previous grant is registered; the work is done by the
// single shared 17-step restoring divider that serves the requesters in turn.
// Reset: weights go to 1, load budget to 4, all deficits to zero, block idle.
module weighted_token_share_allocator
    import wtsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // tick channel
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    // grant channel
    output logic              grant_valid,
    input  logic              grant_stall,
    output grant_t            grant,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_STORE,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             idx_reg, idx_next;
    logic [NUM_REQ-1:0]     act_reg, act_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [DEFICIT_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   idle_tick_reg, idle_tick_next;
    logic [DEFICIT_W-1:0]   deficit_reg [NUM_REQ];
    logic [DEFICIT_W-1:0]   deficit_next [NUM_REQ];
    logic [TOKEN_W-1:0]     tok_reg [NUM_REQ];
    logic [TOKEN_W-1:0]     tok_next [NUM_REQ];
    logic [WEIGHT_W-1:0]    weight_reg [NUM_REQ];
    logic [WEIGHT_W-1:0]    weight_next [NUM_REQ];
    logic [WEIGHT_W-1:0]    budget_reg, budget_next;
    grant_t                 grant_reg, grant_next;
    logic                   grant_valid_reg, grant_valid_next;

    logic                   cfg_we;
    reg_idx_t               cfg_idx;
    logic                   accept;
    logic [TOTAL_W-1:0]     in_total;
    logic [2*WEIGHT_W-1:0]  product;
    logic [SUM_W-1:0]       load_sum;
    logic [DEFICIT_W:0]     trial;
    logic [DEFICIT_W:0]     diff;
    logic                   trial_ge;
    logic [TOKEN_W-1:0]     sat_tokens;

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            REG_FIRST_WEIGHT:  prdata = {24'd0, weight_reg[0]};
            REG_SECOND_WEIGHT: prdata = {24'd0, weight_reg[1]};
            REG_THIRD_WEIGHT:  prdata = {24'd0, weight_reg[2]};
            REG_LOAD_BUDGET:   prdata = {24'd0, budget_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign grant_valid = grant_valid_reg;
    assign grant       = grant_reg;

    // Total active weight of the incoming tick
    assign in_total = (req.first_has_work  ? TOTAL_W'(weight_reg[0]) : '0)
                    + (req.second_has_work ? TOTAL_W'(weight_reg[1]) : '0)
                    + (req.third_has_work  ? TOTAL_W'(weight_reg[2]) : '0);

    // Deficit plus this tick's share for the selected requester
    assign product  = weight_reg[idx_reg] * budget_reg;
    assign load_sum = SUM_W'(deficit_reg[idx_reg]) + SUM_W'(product);

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, total_reg});
    assign diff     = trial - {1'b0, total_reg};

    // Clamp the quotient to the token range
    assign sat_tokens = (|quo_reg[SUM_W-1:TOKEN_W]) ? TOKEN_MAX : quo_reg[TOKEN_W-1:0];

    // Sequencer and register next values
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        act_next         = act_reg;
        total_next       = total_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        idle_tick_next   = idle_tick_reg;
        deficit_next     = deficit_reg;
        tok_next         = tok_reg;
        weight_next      = weight_reg;
        budget_next      = budget_reg;
        grant_next       = grant_reg;
        grant_valid_next = grant_valid_reg;

        // drop the grant once taken
        if (grant_valid_reg && !grant_stall)
        begin
            grant_valid_next = 1'b0;
        end

        // configuration writes also clear the deficits
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FIRST_WEIGHT:  weight_next[0] = pwdata[WEIGHT_W-1:0];
                REG_SECOND_WEIGHT: weight_next[1] = pwdata[WEIGHT_W-1:0];
                REG_THIRD_WEIGHT:  weight_next[2] = pwdata[WEIGHT_W-1:0];
                REG_LOAD_BUDGET:   budget_next    = pwdata[WEIGHT_W-1:0];
                default:           budget_next    = budget_reg;
            endcase
            for (int i = 0; i < NUM_REQ; i++)
            begin
                deficit_next[i] = '0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = {req.third_has_work, req.second_has_work,
                                  req.first_has_work};
                    total_next = in_total;
                    idx_next   = 2'd0;
                    for (int i = 0; i < NUM_REQ; i++)
                    begin
                        tok_next[i] = '0;
                    end
                    if (in_total == '0)
                    begin
                        idle_tick_next = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        idle_tick_next = 1'b0;
                        state_next     = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                if (act_reg[idx_reg])
                begin
                    quo_next   = load_sum;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    tok_next[idx_reg] = '0;
                    if (idx_reg == 2'(NUM_REQ - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end

            ST_DIVIDE:
            begin
                rem_next = trial_ge ? diff[DEFICIT_W-1:0] : trial[DEFICIT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_STORE;
                end
            end

            ST_STORE:
            begin
                deficit_next[idx_reg] = rem_reg;
                tok_next[idx_reg]     = sat_tokens;
                if (idx_reg == 2'(NUM_REQ - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!grant_valid_reg || !grant_stall)
                begin
                    grant_next.first_tokens    = tok_reg[0];
                    grant_next.second_tokens   = tok_reg[1];
                    grant_next.third_tokens    = tok_reg[2];
                    grant_next.nothing_pending = idle_tick_reg;
                    grant_valid_next           = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            grant_valid_reg <= 1'b0;
            grant_reg       <= '0;
            weight_reg[0]   <= WEIGHT_RESET;
            weight_reg[1]   <= WEIGHT_RESET;
            weight_reg[2]   <= WEIGHT_RESET;
            budget_reg      <= BUDGET_RESET;
            for (int i = 0; i < NUM_REQ; i++)
            begin
                deficit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            grant_valid_reg <= grant_valid_next;
            grant_reg       <= grant_next;
            weight_reg      <= weight_next;
            budget_reg      <= budget_next;
            deficit_reg     <= deficit_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        total_reg     <= total_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        idle_tick_reg <= idle_tick_next;
        tok_reg       <= tok_next;
    end

    // An accepted tick always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("block ready right after accepting a tick");

    // Stored deficits stay below the largest possible total weight
    a_deficit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (deficit_reg[0] < 10'd765) && (deficit_reg[1] < 10'd765)
        && (deficit_reg[2] < 10'd765))
        else $error("deficit out of range");

    // The partial remainder never reaches the divisor
    a_rem_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < total_reg))
        else $error("divider remainder not reduced");

    // An idle tick grants nothing
    a_idle_no_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        (grant_valid && grant.nothing_pending) |->
        ((grant.first_tokens == '0) && (grant.second_tokens == '0)
         && (grant.third_tokens == '0)))
        else $error("tokens granted on an idle tick");

endmodule
